FILE: hw/rtl/fra_pkg.sv
package fra_pkg;

    // Queue of retired ranges
    localparam int INFLIGHT_DEPTH = 16;
    localparam int IDX_W          = $clog2(INFLIGHT_DEPTH);
    localparam int CNT_W          = $clog2(INFLIGHT_DEPTH + 1);

    // Field widths
    localparam int OFS_W   = 25;
    localparam int ALIGN_W = 13;
    localparam int FENCE_W = 64;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [OFS_W-1:0] MAX_CAPACITY = 25'd16777216;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETIRE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STAT_W-1:0] ST_COLLIDE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Microprogram steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ALIGN    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_GRANT    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_RETIRE   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_COL_WAIT = 3'd4;
    localparam logic [STEP_W-1:0] STEP_COL_TEST = 3'd5;
    localparam logic [STEP_W-1:0] STEP_COL_END  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_NOP      = 3'd7;

    // Branch kinds
    localparam int BR_W = 2;
    localparam logic [BR_W-1:0] BR_DISPATCH = 2'd0;  // take next request or go idle
    localparam logic [BR_W-1:0] BR_NEXT     = 2'd1;  // fall through
    localparam logic [BR_W-1:0] BR_LOOP     = 2'd2;  // pop_ok ? target : fall through

    // Datapath actions
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALIGN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RETIRE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_COLLECT = 3'd5;

    typedef struct packed {
        logic              take;
        logic              emit;
        logic [BR_W-1:0]   br;
        logic [ACT_W-1:0]  act;
        logic [STEP_W-1:0] target;
    } cw_t;

    // Sequencer to datapath
    typedef struct packed {
        logic             accept;
        logic             fire;
        logic             emit;
        logic [ACT_W-1:0] act;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } sts_t;

    function automatic cw_t ucode(input logic [STEP_W-1:0] step);
        cw_t cw;
        unique case (step)
            STEP_IDLE:     cw = '{1'b1, 1'b0, BR_DISPATCH, ACT_NONE,    STEP_IDLE};
            STEP_ALIGN:    cw = '{1'b0, 1'b0, BR_NEXT,     ACT_ALIGN,   STEP_IDLE};
            STEP_GRANT:    cw = '{1'b1, 1'b1, BR_DISPATCH, ACT_GRANT,   STEP_IDLE};
            STEP_RETIRE:   cw = '{1'b1, 1'b1, BR_DISPATCH, ACT_RETIRE,  STEP_IDLE};
            STEP_COL_WAIT: cw = '{1'b0, 1'b0, BR_NEXT,     ACT_NONE,    STEP_IDLE};
            STEP_COL_TEST: cw = '{1'b0, 1'b0, BR_LOOP,     ACT_POP,     STEP_COL_WAIT};
            STEP_COL_END:  cw = '{1'b1, 1'b1, BR_DISPATCH, ACT_COLLECT, STEP_IDLE};
            STEP_NOP:      cw = '{1'b1, 1'b1, BR_DISPATCH, ACT_NONE,    STEP_IDLE};
            default:       cw = '{1'b1, 1'b0, BR_DISPATCH, ACT_NONE,    STEP_IDLE};
        endcase
        return cw;
    endfunction

    function automatic logic [STEP_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
        logic [STEP_W-1:0] step;
        unique case (cmd)
            CMD_ALLOC:   step = STEP_ALIGN;
            CMD_RETIRE:  step = STEP_RETIRE;
            CMD_COLLECT: step = STEP_COL_WAIT;
            CMD_NONE:    step = STEP_NOP;
            default:     step = STEP_NOP;
        endcase
        return step;
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(INFLIGHT_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage

FILE: hw/rtl/fra_queue.sv
module fra_queue (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [fra_pkg::IDX_W-1:0]     wr_idx,
    input  logic [fra_pkg::OFS_W-1:0]     wr_end,
    input  logic [fra_pkg::FENCE_W-1:0]   wr_fence,
    input  logic [fra_pkg::IDX_W-1:0]     rd_idx,
    output logic [fra_pkg::OFS_W-1:0]     rd_end,
    output logic [fra_pkg::FENCE_W-1:0]   rd_fence
);

    logic [fra_pkg::OFS_W-1:0]   end_mem   [fra_pkg::INFLIGHT_DEPTH];
    logic [fra_pkg::FENCE_W-1:0] fence_mem [fra_pkg::INFLIGHT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            end_mem[wr_idx]   <= wr_end;
            fence_mem[wr_idx] <= wr_fence;
        end
    end

    // registered read of the addressed entry
    always_ff @(posedge clk)
    begin
        rd_end   <= end_mem[rd_idx];
        rd_fence <= fence_mem[rd_idx];
    end

endmodule

FILE: hw/rtl/fra_dp.sv
module fra_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fra_pkg::ctl_t                 ctl,
    output fra_pkg::sts_t                 sts,
    input  logic                          cfg_wr_en,
    input  logic [fra_pkg::OFS_W-1:0]     cfg_wr_data,
    input  logic [fra_pkg::OFS_W-1:0]     in_size,
    input  logic [fra_pkg::ALIGN_W-1:0]   in_align,
    input  logic [fra_pkg::FENCE_W-1:0]   in_fence,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fra_pkg::STAT_W-1:0]    out_status,
    output logic [fra_pkg::OFS_W-1:0]     out_offset,
    output logic [fra_pkg::OFS_W-1:0]     out_granted,
    output logic [fra_pkg::CNT_W-1:0]     out_count
);

    localparam int OW = fra_pkg::OFS_W;
    localparam int AW = fra_pkg::ALIGN_W;

    logic [OW-1:0]               cap_reg;
    logic [OW-1:0]               head_reg, head_next;
    logic [OW-1:0]               tail_reg, tail_next;
    logic [OW-1:0]               pend_end_reg, pend_end_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [fra_pkg::IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [fra_pkg::IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [fra_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OW-1:0]               size_reg;
    logic [AW-1:0]               align_reg;
    logic [fra_pkg::FENCE_W-1:0] fence_reg;
    logic [OW:0]                 aligned_reg;
    logic                        out_valid_reg;
    logic [fra_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [OW-1:0]               offset_reg, offset_next;
    logic [OW-1:0]               granted_reg, granted_next;
    logic [fra_pkg::CNT_W-1:0]   count_reg;

    logic [AW-1:0]               a_m1;
    logic [OW:0]                 align_sum;
    logic [OW:0]                 aligned_c;
    logic [OW+1:0]               end_c;
    logic                        wrap;
    logic                        q_full;
    logic                        q_wr_en;
    logic                        pop_fire;
    logic [OW-1:0]               q_rd_end;
    logic [fra_pkg::FENCE_W-1:0] q_rd_fence;

    function automatic logic [fra_pkg::IDX_W-1:0] IDX_W_DIFF(
        input logic [fra_pkg::IDX_W-1:0] w,
        input logic [fra_pkg::IDX_W-1:0] r
    );
        return w - r;
    endfunction

    fra_queue u_queue (
        .clk      (clk),
        .wr_en    (q_wr_en),
        .wr_idx   (wr_idx_reg),
        .wr_end   (pend_end_reg),
        .wr_fence (fence_reg),
        .rd_idx   (rd_idx_reg),
        .rd_end   (q_rd_end),
        .rd_fence (q_rd_fence)
    );

    // Round tail up: alignment 0 acts as 1
    assign a_m1      = (align_reg == '0) ? '0 : align_reg - AW'(1);
    assign align_sum = {1'b0, tail_reg} + {{(OW + 1 - AW){1'b0}}, a_m1};
    assign aligned_c = align_sum & ~{{(OW + 1 - AW){1'b0}}, a_m1};

    assign end_c  = {1'b0, aligned_reg} + {2'b00, size_reg};
    assign wrap   = end_c > {2'b00, cap_reg};
    assign q_full = (cnt_reg == fra_pkg::CNT_W'(fra_pkg::INFLIGHT_DEPTH));

    assign sts.pop_ok   = (cnt_reg != '0) && (q_rd_fence <= fence_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign q_wr_en  = ctl.fire && (ctl.act == fra_pkg::ACT_RETIRE) && pend_valid_reg
                      && !q_full;
    assign pop_fire = ctl.fire && (ctl.act == fra_pkg::ACT_POP) && sts.pop_ok;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        pend_end_next   = pend_end_reg;
        pend_valid_next = pend_valid_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        cnt_next        = cnt_reg;
        status_next     = fra_pkg::ST_OK;
        offset_next     = '0;
        granted_next    = '0;

        if (ctl.fire)
        begin
            case (ctl.act)
                fra_pkg::ACT_GRANT:
                begin
                    if (wrap)
                    begin
                        if (size_reg > head_reg)
                        begin
                            status_next = fra_pkg::ST_OOM;
                        end
                        else
                        begin
                            tail_next       = size_reg;
                            pend_end_next   = size_reg;
                            pend_valid_next = 1'b1;
                            granted_next    = size_reg;
                        end
                    end
                    else if (aligned_reg < {1'b0, head_reg} && end_c > {2'b00, head_reg})
                    begin
                        status_next = fra_pkg::ST_COLLIDE;
                    end
                    else
                    begin
                        tail_next       = end_c[OW-1:0];
                        pend_end_next   = end_c[OW-1:0];
                        pend_valid_next = 1'b1;
                        offset_next     = aligned_reg[OW-1:0];
                        granted_next    = size_reg;
                    end
                end
                fra_pkg::ACT_RETIRE:
                begin
                    if (pend_valid_reg)
                    begin
                        if (q_full)
                        begin
                            status_next = fra_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_idx_next     = fra_pkg::next_idx(wr_idx_reg);
                            cnt_next        = cnt_reg + fra_pkg::CNT_W'(1);
                            pend_valid_next = 1'b0;
                        end
                    end
                end
                fra_pkg::ACT_POP:
                begin
                    if (sts.pop_ok)
                    begin
                        head_next   = q_rd_end;
                        rd_idx_next = fra_pkg::next_idx(rd_idx_reg);
                        cnt_next    = cnt_reg - fra_pkg::CNT_W'(1);
                    end
                end
                fra_pkg::ACT_COLLECT:
                begin
                    if (cnt_reg == '0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= fra_pkg::MAX_CAPACITY;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_end_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                // clamp to the largest ring
                cap_reg <= (cfg_wr_data > fra_pkg::MAX_CAPACITY) ? fra_pkg::MAX_CAPACITY
                                                                 : cfg_wr_data;
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pend_end_reg   <= pend_end_next;
            pend_valid_reg <= pend_valid_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            cnt_reg        <= cnt_next;
            if (ctl.fire && ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            size_reg  <= in_size;
            align_reg <= in_align;
            fence_reg <= in_fence;
        end
        if (ctl.fire && (ctl.act == fra_pkg::ACT_ALIGN))
        begin
            aligned_reg <= aligned_c;
        end
        if (ctl.fire && ctl.emit)
        begin
            status_reg  <= status_next;
            offset_reg  <= offset_next;
            granted_reg <= granted_next;
            count_reg   <= cnt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = status_reg;
    assign out_offset  = offset_reg;
    assign out_granted = granted_reg;
    assign out_count   = count_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fra_pkg::CNT_W'(fra_pkg::INFLIGHT_DEPTH))
        else $error("retire queue count beyond depth");

    a_idx_track: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[fra_pkg::IDX_W-1:0] == IDX_W_DIFF(wr_idx_reg, rd_idx_reg))
        else $error("queue indexes disagree with count");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> (cnt_reg == $past(cnt_reg) - fra_pkg::CNT_W'(1))
                     && (head_reg == $past(q_rd_end)))
        else $error("pop did not move head and count");

    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && (ctl.act == fra_pkg::ACT_COLLECT) && (cnt_reg == '0))
        |=> (head_reg == '0) && (tail_reg == '0))
        else $error("empty collect left ring offsets");

endmodule

FILE: hw/rtl/fra_seq.sv
module fra_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [fra_pkg::CMD_W-1:0]   in_cmd,
    output logic                        in_ready,
    input  fra_pkg::sts_t               sts,
    output fra_pkg::ctl_t               ctl
);

    logic [fra_pkg::STEP_W-1:0] upc_reg, upc_next;
    fra_pkg::cw_t               cw;
    logic                       advance;

    assign cw = fra_pkg::ucode(upc_reg);

    // a step that produces a result waits for a free output slot
    assign advance  = !cw.emit || sts.out_free;
    assign in_ready = cw.take && advance;

    assign ctl.accept = in_valid && in_ready;
    assign ctl.fire   = advance;
    assign ctl.emit   = cw.emit;
    assign ctl.act    = cw.act;

    always_comb
    begin
        unique case (cw.br)
            fra_pkg::BR_DISPATCH:
            begin
                if (!advance)
                begin
                    upc_next = upc_reg;
                end
                else if (in_valid)
                begin
                    upc_next = fra_pkg::dispatch(in_cmd);
                end
                else
                begin
                    upc_next = fra_pkg::STEP_IDLE;
                end
            end
            fra_pkg::BR_NEXT:
            begin
                upc_next = upc_reg + fra_pkg::STEP_W'(1);
            end
            fra_pkg::BR_LOOP:
            begin
                upc_next = sts.pop_ok ? cw.target : upc_reg + fra_pkg::STEP_W'(1);
            end
            default:
            begin
                upc_next = fra_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= fra_pkg::STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: hw/rtl/fenced_ring_allocator.sv
// Steps, accept to result: allocate runs an align step and then a grant step; retire and the
// unused command finish in the step they dispatch to; collect waits for a queue read, tests the
// head entry's fence, pops and loops while it has completed, then ends. A new request is taken in
// the step that finishes the previous one; retire runs at one per cycle while the result slot is free.
// Reset (rst_n low, asynchronous): capacity returns to the maximum ring size, ring
// offsets, pending range and retire queue are emptied; queue storage is not cleared.
module fenced_ring_allocator (
    input  logic         clk,
    input  logic         rst_n,

    // Capacity register
    input  logic         cfg_wr_en,
    input  logic [24:0]  cfg_wr_data,

    // Requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,    // size_bytes[24:0], alignment[37:25], fence_value[101:38]
    input  logic [1:0]   s_tuser,    // cmd[1:0]

    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,    // offset[24:0], granted_size[49:25], in_flight_count[54:50]
    output logic [1:0]   m_tuser     // status[1:0]
);

    fra_pkg::ctl_t ctl;
    fra_pkg::sts_t sts;

    logic [fra_pkg::OFS_W-1:0]  res_offset;
    logic [fra_pkg::OFS_W-1:0]  res_granted;
    logic [fra_pkg::CNT_W-1:0]  res_count;
    logic [fra_pkg::STAT_W-1:0] res_status;

    // Sequencer: steps through the microprogram, picks the entry step from cmd,
    // loops on the collect test while the head entry's fence has completed.
    fra_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Datapath: ring offsets, pending range, retire queue and the result register.
    fra_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_size     (s_tdata[24:0]),
        .in_align    (s_tdata[37:25]),
        .in_fence    (s_tdata[101:38]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (res_status),
        .out_offset  (res_offset),
        .out_granted (res_granted),
        .out_count   (res_count)
    );

    // Pack result fields, low bits first; pad to whole bytes
    assign m_tdata = {1'b0, res_count, res_granted, res_offset};
    assign m_tuser = res_status;

endmodule

FILE: tb/sv/tb_fenced_ring_allocator.sv
module tb_fenced_ring_allocator;

    import fra_pkg::*;

    // Quiet cycles (no request or result moving) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // Settle time after the last result, sized from the retire queue depth
    localparam int DRAIN_CYCLES   = 3 + 2 * INFLIGHT_DEPTH + 8;

    typedef struct {
        logic [OFS_W-1:0]   stop;
        logic [FENCE_W-1:0] fence;
    } retired_range_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [OFS_W-1:0]  offset;
        logic [OFS_W-1:0]  granted;
        logic [CNT_W-1:0]  count;
    } alloc_reply_t;

    // Shadow of the allocator: ring offsets, open range and retire queue, plus the
    // replies still owed by the block, oldest first.
    class ring_scoreboard;
        logic [OFS_W-1:0] cap_bytes;
        logic [OFS_W-1:0] ring_head;
        logic [OFS_W-1:0] ring_tail;
        logic [OFS_W-1:0] open_end;
        logic             open_valid;
        retired_range_t   retired[$];
        alloc_reply_t     replies_due[$];
        int               errors;

        function new();
            cap_bytes  = MAX_CAPACITY;
            ring_head  = '0;
            ring_tail  = '0;
            open_end   = '0;
            open_valid = 1'b0;
            errors     = 0;
        endfunction

        function void set_capacity(logic [OFS_W-1:0] value);
            cap_bytes = (value > MAX_CAPACITY) ? MAX_CAPACITY : value;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [OFS_W-1:0] size,
                                   logic [ALIGN_W-1:0] align, logic [FENCE_W-1:0] fence);
            alloc_reply_t    reply;
            retired_range_t  entry;
            longint unsigned align_unit;
            longint unsigned aligned;
            longint unsigned stop;
            reply = '{ST_OK, '0, '0, '0};
            case (cmd)
                CMD_ALLOC:
                begin
                    // Non power-of-two alignments go through the same mask on purpose
                    align_unit = (align == '0) ? 1 : align;
                    aligned    = (ring_tail + align_unit - 1) & ~(align_unit - 1);
                    stop       = aligned + size;
                    if (stop > cap_bytes)
                    begin
                        // Wrap to zero only if the request fits below head
                        if (size > ring_head)
                            reply.status = ST_OOM;
                        else
                        begin
                            ring_tail     = size;
                            open_end      = size;
                            open_valid    = 1'b1;
                            reply.granted = size;
                        end
                    end
                    else if (aligned < ring_head && stop > ring_head)
                        reply.status = ST_COLLIDE;
                    else
                    begin
                        ring_tail     = stop[OFS_W-1:0];
                        open_end      = stop[OFS_W-1:0];
                        open_valid    = 1'b1;
                        reply.offset  = aligned[OFS_W-1:0];
                        reply.granted = size;
                    end
                end
                CMD_RETIRE:
                begin
                    if (open_valid)
                    begin
                        if (retired.size() >= INFLIGHT_DEPTH)
                            reply.status = ST_FULL;
                        else
                        begin
                            entry.stop  = open_end;
                            entry.fence = fence;
                            retired.insert(retired.size(), entry);
                            open_valid = 1'b0;
                        end
                    end
                end
                CMD_COLLECT:
                begin
                    while (retired.size() > 0 && retired[0].fence <= fence)
                    begin
                        ring_head = retired[0].stop;
                        retired.delete(0);
                    end
                    if (retired.size() == 0)
                    begin
                        ring_head = '0;
                        ring_tail = '0;
                    end
                end
                default: ;
            endcase
            reply.count = CNT_W'(retired.size());
            replies_due.insert(replies_due.size(), reply);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [OFS_W-1:0] offset,
                                   logic [OFS_W-1:0] granted, logic [CNT_W-1:0] count);
            alloc_reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("result with no request outstanding: status %0d offset %0d",
                       status, offset);
                errors++;
                return;
            end
            want = replies_due[0];
            replies_due.delete(0);
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (offset !== want.offset)
            begin
                $error("offset: expected %0d, actual %0d", want.offset, offset);
                errors++;
            end
            if (granted !== want.granted)
            begin
                $error("granted_size: expected %0d, actual %0d", want.granted, granted);
                errors++;
            end
            if (count !== want.count)
            begin
                $error("in_flight_count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [24:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;    // size_bytes[24:0], alignment[37:25], fence_value[101:38]
    logic [1:0]   s_tuser;    // cmd[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;    // offset[24:0], granted_size[49:25], in_flight_count[54:50]
    logic [1:0]   m_tuser;    // status[1:0]

    ring_scoreboard sb = new();

    // Percent of cycles in which the sender holds off or the receiver stalls
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Next fence handed to an ordered retire; collects are aimed just below it
    logic [FENCE_W-1:0] next_fence;

    fenced_ring_allocator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample results at each edge, then pick the ready level for the next cycle
    initial
    begin : result_monitor
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[24:0], m_tdata[49:25], m_tdata[54:50]);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Reset any count of quiet cycles on a handshake; give up once it hits the limit
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive one request and hold it until taken. Valid is left high on return so a
    // following request goes out back to back; the idle loop lowers it otherwise.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [OFS_W-1:0] size,
                                logic [ALIGN_W-1:0] align, logic [FENCE_W-1:0] fence);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, fence, align, size};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(cmd, size, align, fence);
    endtask

    // Drop valid and wait until every owed reply has come back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Write the ring size; only called with nothing in flight
    task automatic write_capacity(logic [OFS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Mostly powers of two up to 4096, sometimes zero or an arbitrary 13-bit value
    function automatic logic [ALIGN_W-1:0] pick_alignment();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return ALIGN_W'($urandom);
        return ALIGN_W'(1) << $urandom_range(12);
    endfunction

    // One random request. Most are well-formed: allocations sized against the ring,
    // retires with rising fences and collects aimed near the newest fence. The rest
    // are noise with every field random, and unused commands.
    task automatic random_request(int collect_pct, int size_div);
        int                 roll;
        int                 span;
        logic [CMD_W-1:0]   cmd;
        logic [FENCE_W-1:0] fence;
        roll = $urandom_range(99);
        span = sb.cap_bytes / size_div;
        if (span == 0)
            span = 1;
        if (roll >= 50 && roll < 68)
        begin
            fence = next_fence;
            next_fence += $urandom_range(3, 1);
            send_request(CMD_RETIRE, OFS_W'($urandom), ALIGN_W'($urandom), fence);
        end
        else if (roll >= 68 && roll < 68 + collect_pct)
        begin
            case ($urandom_range(7))
                0:       fence = '1;
                1:       fence = '0;
                default: fence = next_fence - $urandom_range(10, 1);
            endcase
            send_request(CMD_COLLECT, OFS_W'($urandom), ALIGN_W'($urandom), fence);
        end
        else if (roll >= 88 && roll < 96)
        begin
            cmd = CMD_W'($urandom_range(3));
            // Keep the retire queue filling in phases that hold back collects
            if (collect_pct == 0 && cmd == CMD_COLLECT)
                cmd = CMD_RETIRE;
            send_request(cmd, OFS_W'($urandom), ALIGN_W'($urandom),
                         {$urandom, $urandom});
        end
        else if (roll >= 96)
            send_request(CMD_NONE, OFS_W'($urandom), ALIGN_W'($urandom),
                         {$urandom, $urandom});
        else
            send_request(CMD_ALLOC, OFS_W'($urandom_range(span)), pick_alignment(),
                         {$urandom, $urandom});
    endtask

    // Drain, set the ring size and idling pattern, then run a batch of random requests
    task automatic run_phase(logic [OFS_W-1:0] capacity, int idle_pct, int stall_pct,
                             int collect_pct, int size_div, int count);
        drain_replies();
        write_capacity(capacity);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count)
            random_request(collect_pct, size_div);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_NONE;
        next_fence  = {$urandom, $urandom};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset ring size: the unused command, collect on an
        // empty queue, retire with nothing open, a grant of the whole ring, requests that
        // take the wrap path and run out of memory, a retire and collects up to its fence.
        send_request(CMD_NONE, '1, '1, '1);
        send_request(CMD_COLLECT, '0, '0, '0);
        send_request(CMD_RETIRE, '0, '0, '1);
        send_request(CMD_ALLOC, MAX_CAPACITY, '0, '0);
        send_request(CMD_ALLOC, 25'd1, 13'd4096, '0);
        send_request(CMD_ALLOC, '1, '1, '0);
        send_request(CMD_RETIRE, '0, '0, 64'd5);
        send_request(CMD_COLLECT, '0, '0, 64'd4);
        send_request(CMD_COLLECT, '0, '0, 64'd5);

        // Small ring: aligned grants, partial collect, wrap to zero below head, a
        // head collision, a grant ending exactly at head, a zero-size grant and a
        // collect with the largest fence.
        drain_replies();
        write_capacity(25'd64);
        send_request(CMD_ALLOC, 25'd16, 13'd0, '0);
        send_request(CMD_ALLOC, 25'd8, 13'd32, '0);
        send_request(CMD_RETIRE, '0, '0, 64'd10);
        send_request(CMD_ALLOC, 25'd20, 13'd0, '0);
        send_request(CMD_RETIRE, '0, '0, 64'd11);
        send_request(CMD_COLLECT, '0, '0, 64'd10);
        send_request(CMD_ALLOC, 25'd8, 13'd0, '0);
        send_request(CMD_ALLOC, 25'd40, 13'd1, '0);
        send_request(CMD_ALLOC, 25'd32, 13'd0, '0);
        send_request(CMD_ALLOC, 25'd1, 13'd0, '0);
        send_request(CMD_RETIRE, '0, '0, '1);
        send_request(CMD_COLLECT, '0, '0, 64'd11);
        send_request(CMD_ALLOC, 25'd0, 13'd0, '0);
        send_request(CMD_COLLECT, '0, '0, '1);

        // Random phases across ring sizes, including zero, one and above the maximum.
        // The phase with no collects runs the retire queue full.
        run_phase(MAX_CAPACITY,           0,  0, 18,  6,  90);
        run_phase(25'd1,                 81,  0, 18,  1,  90);
        run_phase(25'd4096,               0, 81,  0, 64, 160);
        run_phase(25'd0,                 10, 10, 18,  1,  60);
        run_phase('1,                     0,  0, 15,  6,  90);
        run_phase(25'd256,               81,  0, 18,  8,  90);
        run_phase(OFS_W'($urandom_range(MAX_CAPACITY, 2)), 0, 81, 18, 6, 90);
        run_phase(25'd1000,              10, 10, 18,  8,  70);

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
